[hdl/crcp_pkg.sv]
package crcp_pkg;

    // Width of the tolerance register
    localparam int TOL_W = 8;

    // Reset value of the tolerance, 6 in coordinate units (LSBs)
    localparam logic [TOL_W-1:0] TOL_RESET = 8'd6;

    // Width of the contact kind field
    localparam int KIND_W = 4;

    // Output tuser: hit in bit 0, contact kind above it
    localparam int OUT_USER_W = 1 + KIND_W;

    typedef enum logic [KIND_W-1:0] {
        KIND_NONE   = 4'd0,
        KIND_BOTTOM = 4'd1,
        KIND_LEFT   = 4'd2,
        KIND_TOP    = 4'd3,
        KIND_RIGHT  = 4'd4,
        KIND_TR     = 4'd5,
        KIND_BR     = 4'd6,
        KIND_TL     = 4'd7,
        KIND_BL     = 4'd8
    } t_kind;

    // Edge contact flags, one per rectangle edge
    typedef struct packed {
        logic bottom;
        logic left;
        logic top;
        logic right;
    } t_edge_flags;

    // Per-axis distance within reach of the circle
    typedef struct packed {
        logic x_r;
        logic x_l;
        logic y_t;
        logic y_b;
    } t_near;

endpackage

[hdl/circle_rect_contact_point.sv]
// Circle versus axis-aligned rectangle contact test (y grows upward).
// Slave stream: one transaction carries a circle (center, radius) and a
// rectangle (left, top, right, bottom) in signed fixed point.
// Master stream: one transaction per input carries the contact point in
// tdata and the hit flag plus contact kind in tuser.
// Config: i_cfg_wen writes the 8-bit contact tolerance from i_cfg_wdata;
// write it only while no transaction is in flight.
// Pipeline: input register, squaring register and result register lie between
// input acceptance and a valid result on the master side.
// Throughput: one transaction per cycle while the master side accepts; the
// squaring stage and its compare-and-select stage set the cycle budget.
// Reset: the pipeline empties, tvalid drops and the tolerance returns to 6.
// Stall: when m_axis_tready is low the result holds and the pipeline keeps
// filling; s_axis_tready drops only once all three stages hold data.
module circle_rect_contact_point #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Configuration
    input  logic                                i_cfg_wen,
    input  logic [crcp_pkg::TOL_W-1:0]          i_cfg_wdata,
    // Slave stream
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    // center_x, center_y, radius, rect_left, rect_top, rect_right,
    // rect_bottom from bit 0 up, zero padded to whole bytes
    input  logic [((7*COORD_WIDTH-1+7)/8)*8-1:0] s_axis_tdata,
    // Master stream
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    // contact_x, contact_y from bit 0 up, zero padded to whole bytes
    output logic [((2*COORD_WIDTH+7)/8)*8-1:0]  m_axis_tdata,
    // hit, contact_kind from bit 0 up
    output logic [crcp_pkg::OUT_USER_W-1:0]     m_axis_tuser
);
    import crcp_pkg::*;

    localparam int CW       = COORD_WIDTH;
    localparam int OUT_W    = ((2*CW+7)/8)*8;
    localparam int SQ_W     = 2*CW + 2;

    // Field offsets inside the slave tdata
    localparam int OFS_CY   = CW;
    localparam int OFS_R    = 2*CW;
    localparam int OFS_L    = 3*CW - 1;
    localparam int OFS_T    = 4*CW - 1;
    localparam int OFS_RT   = 5*CW - 1;
    localparam int OFS_B    = 6*CW - 1;

    // Tolerance register
    logic [TOL_W-1:0] r_tolerance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tolerance <= TOL_RESET;
        end else if (i_cfg_wen) begin
            r_tolerance <= i_cfg_wdata;
        end
    end

    // Pipeline handshake: each stage moves when the one after it can take data
    logic r_v1, r_v2, r_v3;
    logic n_v1, n_v2, n_v3;
    logic adv1, adv2, adv3;

    assign adv3 = !r_v3 || m_axis_tready;
    assign adv2 = !r_v2 || adv3;
    assign adv1 = !r_v1 || adv2;

    assign s_axis_tready = adv1;

    assign n_v1 = adv1 ? s_axis_tvalid : r_v1;
    assign n_v2 = adv2 ? r_v1 : r_v2;
    assign n_v3 = adv3 ? r_v2 : r_v3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            r_v1 <= n_v1;
            r_v2 <= n_v2;
            r_v3 <= n_v3;
        end
    end

    // Stage 1: input register
    logic signed [CW-1:0] r_cx, r_cy, r_l, r_t, r_rt, r_b;
    logic        [CW-2:0] r_radius;

    always_ff @(posedge i_clk) begin
        if (adv1 && s_axis_tvalid) begin
            r_cx     <= s_axis_tdata[CW-1:0];
            r_cy     <= s_axis_tdata[OFS_CY +: CW];
            r_radius <= s_axis_tdata[OFS_R +: CW-1];
            r_l      <= s_axis_tdata[OFS_L +: CW];
            r_t      <= s_axis_tdata[OFS_T +: CW];
            r_rt     <= s_axis_tdata[OFS_RT +: CW];
            r_b      <= s_axis_tdata[OFS_B +: CW];
        end
    end

    // Edge tests and corner squarings on the registered input
    t_edge_flags          edge_flags;
    t_near                near;
    logic [SQ_W-1:0]      sq_x_r, sq_x_l, sq_y_t, sq_y_b, sq_reach;

    crcp_edge #(.CW(CW)) u_edge (
        .i_cx     (r_cx),
        .i_cy     (r_cy),
        .i_radius (r_radius),
        .i_left   (r_l),
        .i_top    (r_t),
        .i_right  (r_rt),
        .i_bottom (r_b),
        .i_tol    (r_tolerance),
        .o_flags  (edge_flags)
    );

    crcp_corner_sq #(.CW(CW)) u_corner_sq (
        .i_cx       (r_cx),
        .i_cy       (r_cy),
        .i_radius   (r_radius),
        .i_left     (r_l),
        .i_top      (r_t),
        .i_right    (r_rt),
        .i_bottom   (r_b),
        .i_tol      (r_tolerance),
        .o_near     (near),
        .o_sq_x_r   (sq_x_r),
        .o_sq_x_l   (sq_x_l),
        .o_sq_y_t   (sq_y_t),
        .o_sq_y_b   (sq_y_b),
        .o_sq_reach (sq_reach)
    );

    // Stage 2: hold squares, flags and the coordinates needed for the result
    t_edge_flags          r2_flags;
    t_near                r2_near;
    logic [SQ_W-1:0]      r2_sq_x_r, r2_sq_x_l, r2_sq_y_t, r2_sq_y_b, r2_sq_reach;
    logic signed [CW-1:0] r2_cx, r2_cy, r2_l, r2_t, r2_rt, r2_b;

    always_ff @(posedge i_clk) begin
        if (adv2 && r_v1) begin
            r2_flags    <= edge_flags;
            r2_near     <= near;
            r2_sq_x_r   <= sq_x_r;
            r2_sq_x_l   <= sq_x_l;
            r2_sq_y_t   <= sq_y_t;
            r2_sq_y_b   <= sq_y_b;
            r2_sq_reach <= sq_reach;
            r2_cx       <= r_cx;
            r2_cy       <= r_cy;
            r2_l        <= r_l;
            r2_t        <= r_t;
            r2_rt       <= r_rt;
            r2_b        <= r_b;
        end
    end

    // Corner compare and priority select
    logic                 sel_hit;
    logic signed [CW-1:0] sel_px, sel_py;
    t_kind                sel_kind;

    crcp_select #(.CW(CW)) u_select (
        .i_flags    (r2_flags),
        .i_near     (r2_near),
        .i_sq_x_r   (r2_sq_x_r),
        .i_sq_x_l   (r2_sq_x_l),
        .i_sq_y_t   (r2_sq_y_t),
        .i_sq_y_b   (r2_sq_y_b),
        .i_sq_reach (r2_sq_reach),
        .i_cx       (r2_cx),
        .i_cy       (r2_cy),
        .i_left     (r2_l),
        .i_top      (r2_t),
        .i_right    (r2_rt),
        .i_bottom   (r2_b),
        .o_hit      (sel_hit),
        .o_px       (sel_px),
        .o_py       (sel_py),
        .o_kind     (sel_kind)
    );

    // Stage 3: result register, held while the master side stalls
    logic                 r3_hit;
    logic signed [CW-1:0] r3_px, r3_py;
    t_kind                r3_kind;

    always_ff @(posedge i_clk) begin
        if (adv3 && r_v2) begin
            r3_hit  <= sel_hit;
            r3_px   <= sel_px;
            r3_py   <= sel_py;
            r3_kind <= sel_kind;
        end
    end

    assign m_axis_tvalid = r_v3;
    assign m_axis_tdata  = {{(OUT_W-2*CW){1'b0}}, r3_py, r3_px};
    assign m_axis_tuser  = {r3_kind, r3_hit};

    // Hit flag agrees with the kind
    a_hit_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_v3 |-> (r3_hit == (r3_kind != KIND_NONE)))
        else $error("hit flag disagrees with contact kind");

    // No contact means a zero contact point
    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !r3_hit) |-> (r3_px == '0 && r3_py == '0))
        else $error("contact point not zero on a miss");

    // A stalled result is never dropped
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !m_axis_tready) |=> r_v3)
        else $error("stalled result lost");

    // Input stalls only when every stage is full
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !s_axis_tready |-> (r_v1 && r_v2 && r_v3))
        else $error("input stalled with room in the pipeline");

endmodule

[hdl/crcp_edge.sv]
module crcp_edge #(
    parameter int CW = 16
) (
    input  logic signed [CW-1:0]          i_cx,
    input  logic signed [CW-1:0]          i_cy,
    input  logic        [CW-2:0]          i_radius,
    input  logic signed [CW-1:0]          i_left,
    input  logic signed [CW-1:0]          i_top,
    input  logic signed [CW-1:0]          i_right,
    input  logic signed [CW-1:0]          i_bottom,
    input  logic        [crcp_pkg::TOL_W-1:0] i_tol,
    output crcp_pkg::t_edge_flags         o_flags
);
    import crcp_pkg::*;

    localparam int W = CW + 2;

    logic signed [W-1:0] cx, cy, r, l, t, rt, b, tol;
    logic signed [W-1:0] e_up, e_rt, e_dn, e_lf;
    logic                in_x, in_y;

    assign cx  = {{2{i_cx[CW-1]}}, i_cx};
    assign cy  = {{2{i_cy[CW-1]}}, i_cy};
    assign l   = {{2{i_left[CW-1]}}, i_left};
    assign t   = {{2{i_top[CW-1]}}, i_top};
    assign rt  = {{2{i_right[CW-1]}}, i_right};
    assign b   = {{2{i_bottom[CW-1]}}, i_bottom};
    assign r   = {3'b000, i_radius};
    assign tol = {{(W-TOL_W){1'b0}}, i_tol};

    // Center must lie within the edge span widened by the tolerance
    assign in_x = (cx <= rt + tol) && (cx >= l - tol);
    assign in_y = (cy <= t + tol) && (cy >= b - tol);

    // Extreme points of the circle along each axis
    assign e_up = cy + r;
    assign e_rt = cx + r;
    assign e_dn = cy - r;
    assign e_lf = cx - r;

    always_comb begin
        o_flags.bottom = (e_up >= b - tol) && (e_up <= b + tol) && in_x;
        o_flags.left   = (e_rt >= l - tol) && (e_rt <= l + tol) && in_y;
        o_flags.top    = (e_dn <= t + tol) && (e_dn >= t - tol) && in_x;
        o_flags.right  = (e_lf <= rt + tol) && (e_lf >= rt - tol) && in_y;
    end

endmodule

[hdl/crcp_corner_sq.sv]
module crcp_corner_sq #(
    parameter int CW = 16
) (
    input  logic signed [CW-1:0]          i_cx,
    input  logic signed [CW-1:0]          i_cy,
    input  logic        [CW-2:0]          i_radius,
    input  logic signed [CW-1:0]          i_left,
    input  logic signed [CW-1:0]          i_top,
    input  logic signed [CW-1:0]          i_right,
    input  logic signed [CW-1:0]          i_bottom,
    input  logic        [crcp_pkg::TOL_W-1:0] i_tol,
    output crcp_pkg::t_near               o_near,
    output logic        [2*CW+1:0]        o_sq_x_r,
    output logic        [2*CW+1:0]        o_sq_x_l,
    output logic        [2*CW+1:0]        o_sq_y_t,
    output logic        [2*CW+1:0]        o_sq_y_b,
    output logic        [2*CW+1:0]        o_sq_reach
);
    import crcp_pkg::*;

    localparam int MW = CW + 1;

    logic signed [MW-1:0] dx_r, dx_l, dy_t, dy_b;
    logic        [MW-1:0] ax_r, ax_l, ay_t, ay_b;
    logic        [MW-1:0] reach;

    function automatic logic [MW-1:0] magnitude(input logic signed [MW-1:0] d);
        return d[MW-1] ? MW'(-d) : MW'(d);
    endfunction

    assign dx_r = {i_cx[CW-1], i_cx} - {i_right[CW-1], i_right};
    assign dx_l = {i_cx[CW-1], i_cx} - {i_left[CW-1], i_left};
    assign dy_t = {i_cy[CW-1], i_cy} - {i_top[CW-1], i_top};
    assign dy_b = {i_cy[CW-1], i_cy} - {i_bottom[CW-1], i_bottom};

    assign ax_r = magnitude(dx_r);
    assign ax_l = magnitude(dx_l);
    assign ay_t = magnitude(dy_t);
    assign ay_b = magnitude(dy_b);

    assign reach = {2'b00, i_radius} + {{(MW-TOL_W){1'b0}}, i_tol};

    always_comb begin
        o_near.x_r = (ax_r <= reach);
        o_near.x_l = (ax_l <= reach);
        o_near.y_t = (ay_t <= reach);
        o_near.y_b = (ay_b <= reach);
    end

    // Independent squarings, summed and compared in the next stage
    assign o_sq_x_r   = ax_r * ax_r;
    assign o_sq_x_l   = ax_l * ax_l;
    assign o_sq_y_t   = ay_t * ay_t;
    assign o_sq_y_b   = ay_b * ay_b;
    assign o_sq_reach = reach * reach;

endmodule

[hdl/crcp_select.sv]
module crcp_select #(
    parameter int CW = 16
) (
    input  crcp_pkg::t_edge_flags         i_flags,
    input  crcp_pkg::t_near               i_near,
    input  logic        [2*CW+1:0]        i_sq_x_r,
    input  logic        [2*CW+1:0]        i_sq_x_l,
    input  logic        [2*CW+1:0]        i_sq_y_t,
    input  logic        [2*CW+1:0]        i_sq_y_b,
    input  logic        [2*CW+1:0]        i_sq_reach,
    input  logic signed [CW-1:0]          i_cx,
    input  logic signed [CW-1:0]          i_cy,
    input  logic signed [CW-1:0]          i_left,
    input  logic signed [CW-1:0]          i_top,
    input  logic signed [CW-1:0]          i_right,
    input  logic signed [CW-1:0]          i_bottom,
    output logic                          o_hit,
    output logic signed [CW-1:0]          o_px,
    output logic signed [CW-1:0]          o_py,
    output crcp_pkg::t_kind               o_kind
);
    import crcp_pkg::*;

    localparam int SW = 2 * CW + 3;

    logic hit_tr, hit_br, hit_tl, hit_bl;

    function automatic logic in_reach(input logic [SW-2:0] sa, input logic [SW-2:0] sb,
                                      input logic [SW-2:0] lim);
        logic [SW-1:0] s;
        s = {1'b0, sa} + {1'b0, sb};
        return s <= {1'b0, lim};
    endfunction

    assign hit_tr = i_near.x_r && i_near.y_t && in_reach(i_sq_x_r, i_sq_y_t, i_sq_reach);
    assign hit_br = i_near.x_r && i_near.y_b && in_reach(i_sq_x_r, i_sq_y_b, i_sq_reach);
    assign hit_tl = i_near.x_l && i_near.y_t && in_reach(i_sq_x_l, i_sq_y_t, i_sq_reach);
    assign hit_bl = i_near.x_l && i_near.y_b && in_reach(i_sq_x_l, i_sq_y_b, i_sq_reach);

    // Edges first, then corners; first match wins
    always_comb begin
        o_px   = '0;
        o_py   = '0;
        o_kind = KIND_NONE;
        if (i_flags.bottom) begin
            o_px = i_cx;    o_py = i_bottom; o_kind = KIND_BOTTOM;
        end else if (i_flags.left) begin
            o_px = i_left;  o_py = i_cy;     o_kind = KIND_LEFT;
        end else if (i_flags.top) begin
            o_px = i_cx;    o_py = i_top;    o_kind = KIND_TOP;
        end else if (i_flags.right) begin
            o_px = i_right; o_py = i_cy;     o_kind = KIND_RIGHT;
        end else if (hit_tr) begin
            o_px = i_right; o_py = i_top;    o_kind = KIND_TR;
        end else if (hit_br) begin
            o_px = i_right; o_py = i_bottom; o_kind = KIND_BR;
        end else if (hit_tl) begin
            o_px = i_left;  o_py = i_top;    o_kind = KIND_TL;
        end else if (hit_bl) begin
            o_px = i_left;  o_py = i_bottom; o_kind = KIND_BL;
        end
        o_hit = (o_kind != KIND_NONE);
    end

endmodule

[verif/contact_checker.sv]
`timescale 1ns / 100ps

module contact_checker #(
    parameter int COORD_WIDTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_wen,
    input  logic [crcp_pkg::TOL_W-1:0]           i_cfg_wdata,
    input  logic                                 i_in_valid,
    input  logic                                 i_in_ready,
    input  logic [((7*COORD_WIDTH-1+7)/8)*8-1:0] i_in_data,
    input  logic                                 i_out_valid,
    input  logic                                 i_out_ready,
    input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]   i_out_data,
    input  logic [crcp_pkg::OUT_USER_W-1:0]      i_out_user,
    output int                                   o_errors,
    output int                                   o_pending
);

    import crcp_pkg::*;

    localparam int CW     = COORD_WIDTH;
    localparam int IN_W   = ((7*CW-1+7)/8)*8;
    localparam int OFS_R  = 2*CW;
    localparam int OFS_L  = 3*CW-1;
    localparam int OFS_T  = 4*CW-1;
    localparam int OFS_RT = 5*CW-1;
    localparam int OFS_B  = 6*CW-1;
    localparam int MAX_REPORTS = 10;

    typedef struct {
        logic          hit;
        logic [CW-1:0] px;
        logic [CW-1:0] py;
        t_kind         kind;
    } t_contact;

    t_contact          contact_q[$];
    t_contact          want;
    logic [TOL_W-1:0]  tol_q = TOL_RESET;
    int                err_cnt = 0;

    // Corner test: squared distance against squared reach, far axes rejected early
    function automatic bit within_reach(input longint dx, input longint dy,
                                        input longint reach);
        longint ax;
        longint ay;
        ax = (dx < 0) ? -dx : dx;
        ay = (dy < 0) ? -dy : dy;
        if (ax > reach || ay > reach)
            return 1'b0;
        return (ax*ax + ay*ay) <= reach*reach;
    endfunction

    function automatic t_contact find_contact(input logic [IN_W-1:0] d,
                                              input logic [TOL_W-1:0] tol_v);
        longint   cx, cy, r, l, t, rt, b, tol, reach, e, px, py;
        logic     in_x, in_y;
        t_contact c;
        cx    = $signed(d[0 +: CW]);
        cy    = $signed(d[CW +: CW]);
        r     = d[OFS_R +: CW-1];
        l     = $signed(d[OFS_L +: CW]);
        t     = $signed(d[OFS_T +: CW]);
        rt    = $signed(d[OFS_RT +: CW]);
        b     = $signed(d[OFS_B +: CW]);
        tol   = tol_v;
        reach = r + tol;
        in_x  = (cx <= rt + tol) && (cx >= l - tol);
        in_y  = (cy <= t + tol) && (cy >= b - tol);
        px    = 0;
        py    = 0;
        c.kind = KIND_NONE;
        e = cy + r;
        if (e >= b - tol && e <= b + tol && in_x) begin
            px = cx; py = b; c.kind = KIND_BOTTOM;
        end else if ((cx + r) >= l - tol && (cx + r) <= l + tol && in_y) begin
            px = l; py = cy; c.kind = KIND_LEFT;
        end else if ((cy - r) <= t + tol && (cy - r) >= t - tol && in_x) begin
            px = cx; py = t; c.kind = KIND_TOP;
        end else if ((cx - r) <= rt + tol && (cx - r) >= rt - tol && in_y) begin
            px = rt; py = cy; c.kind = KIND_RIGHT;
        end else if (within_reach(cx - rt, cy - t, reach)) begin
            px = rt; py = t; c.kind = KIND_TR;
        end else if (within_reach(cx - rt, cy - b, reach)) begin
            px = rt; py = b; c.kind = KIND_BR;
        end else if (within_reach(cx - l, cy - t, reach)) begin
            px = l; py = t; c.kind = KIND_TL;
        end else if (within_reach(cx - l, cy - b, reach)) begin
            px = l; py = b; c.kind = KIND_BL;
        end
        c.hit = (c.kind != KIND_NONE);
        c.px  = px[CW-1:0];
        c.py  = py[CW-1:0];
        return c;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            tol_q = TOL_RESET;
        end else begin
            if (i_in_valid && i_in_ready)
                contact_q.push_back(find_contact(i_in_data, tol_q));
            if (i_out_valid && i_out_ready) begin
                if (contact_q.size() == 0) begin
                    if (err_cnt < MAX_REPORTS)
                        $display("%0t: result with nothing expected: x=%0d y=%0d user=%0h",
                                 $realtime, $signed(i_out_data[0 +: CW]),
                                 $signed(i_out_data[CW +: CW]), i_out_user);
                    err_cnt++;
                end else begin
                    want = contact_q.pop_front();
                    if (i_out_user[0] !== want.hit ||
                        i_out_user[KIND_W:1] !== want.kind ||
                        i_out_data[0 +: CW] !== want.px ||
                        i_out_data[CW +: CW] !== want.py) begin
                        if (err_cnt < MAX_REPORTS)
                            $display({"%0t: mismatch: expected hit=%0b kind=%0d x=%0d y=%0d,",
                                      " got hit=%0b kind=%0d x=%0d y=%0d"},
                                     $realtime, want.hit, want.kind,
                                     $signed(want.px), $signed(want.py),
                                     i_out_user[0], i_out_user[KIND_W:1],
                                     $signed(i_out_data[0 +: CW]),
                                     $signed(i_out_data[CW +: CW]));
                        err_cnt++;
                    end
                end
            end
            if (i_cfg_wen)
                tol_q = i_cfg_wdata;
        end
        o_errors  <= err_cnt;
        o_pending <= contact_q.size();
    end

endmodule

[verif/circle_rect_contact_point_test.sv]
`timescale 1ns / 100ps

module circle_rect_contact_point_test;

    import crcp_pkg::*;

    localparam int CW          = 16;
    localparam int IN_W        = ((7*CW-1+7)/8)*8;
    localparam int OUT_W       = ((2*CW+7)/8)*8;
    localparam int LATENCY     = 3;
    localparam int HOLD_CYCLES = 80;
    localparam int CYCLE_LIMIT = 400000;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_wen = 1'b0;
    logic [TOL_W-1:0]      i_cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    // center_x, center_y, radius, rect_left, rect_top, rect_right, rect_bottom
    logic [IN_W-1:0]       s_axis_tdata = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    // contact_x, contact_y
    logic [OUT_W-1:0]      m_axis_tdata;
    // hit, contact_kind
    logic [OUT_USER_W-1:0] m_axis_tuser;

    int errors;
    int pending;
    int cycles = 0;

    // Receiver behavior, set by the stimulus process
    int   stall_pct = 0;
    logic hold_req = 1'b0;

    // Tolerance currently loaded, used only to aim the shaped stimulus
    int cur_tol = TOL_RESET;

    circle_rect_contact_point #(
        .COORD_WIDTH (CW)
    ) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wen     (i_cfg_wen),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    contact_checker #(
        .COORD_WIDTH (CW)
    ) u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (s_axis_tvalid),
        .i_in_ready  (s_axis_tready),
        .i_in_data   (s_axis_tdata),
        .i_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_out_data  (m_axis_tdata),
        .i_out_user  (m_axis_tuser),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watchdog: abort a hung run
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Receiver: mostly ready, with random stall bursts and one long hold-off
    // on request so the pipeline fills and backpressures the input
    initial begin
        forever begin
            if (hold_req) begin
                hold_req <= 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end else if (int'($urandom_range(0, 99)) < stall_pct) begin
                m_axis_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end else begin
                m_axis_tready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    // Pack one circle/rectangle pair into tdata, lowest field first
    function automatic logic [IN_W-1:0] pack_pair(input int cx, input int cy, input int r,
                                                  input int l, input int t, input int rt,
                                                  input int b);
        logic [IN_W-1:0] d;
        d = '0;
        d[0 +: CW]      = cx[CW-1:0];
        d[CW +: CW]     = cy[CW-1:0];
        d[2*CW +: CW-1] = r[CW-2:0];
        d[3*CW-1 +: CW] = l[CW-1:0];
        d[4*CW-1 +: CW] = t[CW-1:0];
        d[5*CW-1 +: CW] = rt[CW-1:0];
        d[6*CW-1 +: CW] = b[CW-1:0];
        return d;
    endfunction

    // Aim a circle at one edge or corner of a sane rectangle, landing inside
    // or just outside the tolerance band; a few centers fall anywhere
    function automatic logic [IN_W-1:0] aimed_pair();
        int l, b, w, h, rt, t, r, j, cx, cy, dx, dy, reach;
        l  = int'($urandom_range(0, 16000)) - 8000;
        b  = int'($urandom_range(0, 16000)) - 8000;
        w  = $urandom_range(0, 4000);
        h  = $urandom_range(0, 4000);
        rt = l + w;
        t  = b + h;
        r  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 2000);
        j  = int'($urandom_range(0, 2*cur_tol + 8)) - (cur_tol + 4);
        reach = r + cur_tol;
        dx = $urandom_range(0, reach + 4);
        dy = $urandom_range(0, reach + 4);
        cx = l - cur_tol - 4 + int'($urandom_range(0, w + 2*cur_tol + 8));
        cy = b - cur_tol - 4 + int'($urandom_range(0, h + 2*cur_tol + 8));
        case ($urandom_range(0, 8))
            0: cy = b - r + j;
            1: cx = l - r + j;
            2: cy = t + r + j;
            3: cx = rt + r + j;
            4: begin cx = rt + dx; cy = t + dy; end
            5: begin cx = rt + dx; cy = b - dy; end
            6: begin cx = l - dx;  cy = t + dy; end
            7: begin cx = l - dx;  cy = b - dy; end
            default: begin
                cx = int'($urandom_range(0, 20000)) - 10000;
                cy = int'($urandom_range(0, 20000)) - 10000;
            end
        endcase
        return pack_pair(cx, cy, r, l, t, rt, b);
    endfunction

    // Offer one transaction and hold it until the block takes it
    task automatic send_item(input logic [IN_W-1:0] d);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        do @(posedge i_clk); while (!s_axis_tready);
    endtask

    task automatic offer(input int cx, input int cy, input int r, input int l,
                         input int t, input int rt, input int b);
        send_item(pack_pair(cx, cy, r, l, t, rt, b));
    endtask

    // Random transactions: mostly aimed geometry, the rest raw noise
    task automatic run_batch(input int count, input int gap_pct);
        logic [127:0]    raw;
        logic [IN_W-1:0] d;
        repeat (count) begin
            if ($urandom_range(0, 4) == 0) begin
                raw = {$urandom, $urandom, $urandom, $urandom};
                d = raw[IN_W-1:0];
                d[IN_W-1:7*CW-1] = '0;
            end else begin
                d = aimed_pair();
            end
            send_item(d);
            if (int'($urandom_range(0, 99)) < gap_pct) begin
                s_axis_tvalid <= 1'b0;
                repeat ($urandom_range(1, 11)) @(posedge i_clk);
            end
        end
        s_axis_tvalid <= 1'b0;
    endtask

    // Wait for every outstanding result, then let the pipeline settle;
    // step a clock edge first so the count includes the last transaction
    task automatic drain();
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (LATENCY + 2) @(posedge i_clk);
    endtask

    task automatic write_tolerance(input int value);
        i_cfg_wen   <= 1'b1;
        i_cfg_wdata <= value[TOL_W-1:0];
        @(posedge i_clk);
        i_cfg_wen <= 1'b0;
        cur_tol = value;
        @(posedge i_clk);
    endtask

    initial begin
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed pass at the reset tolerance against a 200x200 box at the origin
        stall_pct <= 30;
        offer(0, -150, 50, -100, 100, 100, -100);       // bottom edge
        offer(-150, 0, 50, -100, 100, 100, -100);       // left edge
        offer(0, 150, 50, -100, 100, 100, -100);        // top edge
        offer(150, 0, 50, -100, 100, 100, -100);        // right edge
        offer(130, 130, 50, -100, 100, 100, -100);      // top-right corner
        offer(130, -130, 50, -100, 100, 100, -100);     // bottom-right corner
        offer(-130, 130, 50, -100, 100, 100, -100);     // top-left corner
        offer(-130, -130, 50, -100, 100, 100, -100);    // bottom-left corner
        offer(1000, 1000, 50, -100, 100, 100, -100);    // no contact
        // Edges of the tolerance band, on both sides
        offer(0, -156, 50, -100, 100, 100, -100);
        offer(0, -157, 50, -100, 100, 100, -100);
        offer(0, -144, 50, -100, 100, 100, -100);
        offer(0, -143, 50, -100, 100, 100, -100);
        // Center at the end of the widened span, then just past it
        offer(106, -150, 50, -100, 100, 100, -100);
        offer(107, -150, 50, -100, 100, 100, -100);
        // Corner exactly at reach, then one step beyond
        offer(130, 140, 44, -100, 100, 100, -100);
        offer(131, 140, 44, -100, 100, 100, -100);
        // Far corner: one axis past reach with the other at zero
        offer(157, 100, 50, -100, 100, 100, -100);
        // Inverted rectangle
        offer(0, 50, 50, 100, -100, -100, 100);
        // Field extremes
        offer(0, 0, 0, 0, 0, 0, 0);
        offer(-32768, -32768, 0, -32768, -32768, -32768, -32768);
        offer(32767, 32767, 32767, 32767, 32767, 32767, 32767);
        offer(-32768, 32767, 32767, 32767, -32768, -32768, 32767);
        offer(32767, 32767, 32767, -32768, -32768, -32768, -32768);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);

        // Long receiver hold-off while the sender keeps pushing back to back
        hold_req <= 1'b1;
        run_batch(30, 0);
        drain();

        run_batch(150, 30);
        drain();

        // Zero tolerance, heavy output stalls, no input gaps
        write_tolerance(0);
        stall_pct <= 50;
        run_batch(200, 0);
        drain();

        // Widest tolerance, free-running output, bursty input
        write_tolerance(255);
        stall_pct <= 0;
        run_batch(200, 50);
        drain();

        // Random tolerance, moderate idling on both sides
        write_tolerance($urandom_range(1, 254));
        stall_pct <= 20;
        run_batch(200, 20);
        drain();

        // Back to the default value; final stretch runs at full rate
        write_tolerance(TOL_RESET);
        stall_pct <= 0;
        run_batch(250, 0);

        drain();
        repeat (2*LATENCY) @(posedge i_clk);
        if (errors == 0 && pending == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
